// ----- rtl/led_strip_animation_sequencer_assert.svh -----
`ifndef LED_STRIP_ANIMATION_SEQUENCER_ASSERT_SVH
`define LED_STRIP_ANIMATION_SEQUENCER_ASSERT_SVH

// same-cycle implication under reset
`define LSAS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define LSAS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lsas_pkg.sv -----
package lsas_pkg;

    localparam int PIX_W     = 6;
    localparam int COLOR_W   = 24;
    localparam int BR_W      = 8;
    localparam int CNT_W     = 7;
    localparam int STEP_W    = 6;
    localparam int ANIM_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int STRIP_MAX = 64;

    typedef enum logic [ANIM_W-1:0] {
        MODE_NONE       = 3'd0,
        MODE_CRITICAL   = 3'd1,
        MODE_STARTUP    = 3'd2,
        MODE_ROTATING   = 3'd3,
        MODE_CONNECTION = 3'd4,
        MODE_STATIC     = 3'd5
    } t_mode;

    localparam logic OP_STEP   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT   = 2'd2;

    localparam logic [COLOR_W-1:0] WARNING_RESET = 24'hFF0000;
    localparam logic [COLOR_W-1:0] DIM_RED       = 24'h640000;
    localparam logic [CNT_W-1:0]   COUNT_RESET   = 7'd16;
    localparam logic [BR_W-1:0]    BR_FULL       = 8'd255;
    localparam logic [4:0]         BREATH_LEN    = 5'd20;
    localparam logic [4:0]         BREATH_PEAK   = 5'd10;
    localparam logic [BR_W-1:0]    BREATH_GAIN   = 8'd10;

    typedef struct packed {
        logic load_item;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic silent;
        logic out_free;
        logic at_end;
    } t_dp_sts;

endpackage

// ----- rtl/lsas_datapath.sv -----
module lsas_datapath
    import lsas_pkg::*;
#(
    parameter int MAX_PIXELS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data,
    input  logic                 i_operation,
    input  logic [ANIM_W-1:0]    i_animation,
    input  logic                 i_out_stall,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_out_valid,
    output logic [PIX_W-1:0]     o_pixel_index,
    output logic [COLOR_W-1:0]   o_pixel_color,
    output logic [BR_W-1:0]      o_brightness,
    output logic                 o_accepted,
    output logic                 o_last_pixel
);

    localparam int CAP = (MAX_PIXELS > STRIP_MAX) ? STRIP_MAX :
                         ((MAX_PIXELS < 1) ? 1 : MAX_PIXELS);
    localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAP);

    typedef enum logic [1:0] {
        K_PLAIN,
        K_BLINK,
        K_ROTATE
    } t_kind;

    logic [COLOR_W-1:0] r_frame_color;
    logic [COLOR_W-1:0] r_warning_color;
    logic [CNT_W-1:0]   r_pixel_count;
    t_mode              r_mode, n_mode;
    logic [STEP_W-1:0]  r_step, n_step;

    t_kind              r_kind, n_kind;
    logic [COLOR_W-1:0] r_col, n_col;
    logic [BR_W-1:0]    r_br, n_br;
    logic               r_acc, n_acc;
    logic [PIX_W-1:0]   r_end, n_end;
    logic               r_phase, n_phase;
    logic [PIX_W-1:0]   r_s, n_s;
    logic [PIX_W-1:0]   r_nx, n_nx;
    logic [PIX_W-1:0]   r_pv, n_pv;
    logic [PIX_W-1:0]   r_idx;

    logic               r_out_valid;
    logic [PIX_W-1:0]   r_pixel_index;
    logic [COLOR_W-1:0] r_pixel_color;
    logic [BR_W-1:0]    r_brightness;
    logic               r_accepted;
    logic               r_last_pixel;

    logic [CNT_W-1:0]   strip_n;
    logic [PIX_W-1:0]   nm1;
    logic [PIX_W-1:0]   lit;
    logic [PIX_W-1:0]   rot_s;
    logic [PIX_W-1:0]   rot_nx;
    logic [PIX_W-1:0]   rot_pv;
    logic [4:0]         br_s;
    logic [3:0]         br_d;
    logic               emit;
    logic               at_end;
    logic               out_free;
    logic [COLOR_W-1:0] pix_col;

    always_comb begin
        if (r_pixel_count == '0) begin
            strip_n = CNT_W'(1);
        end else if (r_pixel_count > CAP_N) begin
            strip_n = CAP_N;
        end else begin
            strip_n = r_pixel_count;
        end
        nm1 = PIX_W'(strip_n - CNT_W'(1));

        lit    = ({1'b0, r_step} < strip_n) ? r_step : nm1;
        rot_s  = ({1'b0, r_step} < strip_n) ? r_step : '0;
        rot_nx = (rot_s == nm1) ? '0 : PIX_W'(rot_s + PIX_W'(1));
        rot_pv = (rot_s == '0) ? nm1 : PIX_W'(rot_s - PIX_W'(1));

        br_s = (r_step > STEP_W'(BREATH_LEN)) ? BREATH_LEN : r_step[4:0];
        br_d = (br_s <= BREATH_PEAK) ? br_s[3:0] : 4'(BREATH_LEN - br_s);
    end

    always_comb begin
        n_mode  = r_mode;
        n_step  = r_step;
        n_kind  = K_PLAIN;
        n_col   = '0;
        n_br    = BR_FULL;
        n_acc   = 1'b1;
        n_end   = nm1;
        n_phase = r_step[0];
        n_s     = rot_s;
        n_nx    = rot_nx;
        n_pv    = rot_pv;
        if (i_operation == OP_SELECT) begin
            if (i_animation == r_mode) begin
                n_acc = 1'b0;
                n_end = '0;
            end else begin
                case (i_animation)
                    MODE_CRITICAL: begin
                        n_mode = MODE_CRITICAL;
                        n_step = '0;
                        n_col  = r_warning_color;
                    end
                    MODE_STARTUP: begin
                        n_mode = MODE_STARTUP;
                        n_step = '0;
                    end
                    MODE_ROTATING: begin
                        n_mode = MODE_ROTATING;
                        n_step = '0;
                    end
                    MODE_CONNECTION: begin
                        n_mode = MODE_CONNECTION;
                        n_step = '0;
                    end
                    MODE_STATIC: begin
                        n_mode = MODE_STATIC;
                        n_col  = r_frame_color;
                    end
                    default: begin
                        n_mode = MODE_NONE;
                    end
                endcase
            end
        end else begin
            case (r_mode)
                MODE_CRITICAL: begin
                    n_kind = K_BLINK;
                    n_step = {{(STEP_W-1){1'b0}}, ~r_step[0]};
                end
                MODE_STARTUP: begin
                    n_col  = r_frame_color;
                    n_end  = lit;
                    n_step = STEP_W'(r_step + STEP_W'(1));
                    if (lit == nm1) begin
                        n_mode = MODE_STATIC;
                    end
                end
                MODE_ROTATING: begin
                    n_kind = K_ROTATE;
                    n_col  = r_frame_color;
                    n_end  = (rot_s == '0 || rot_s == nm1) ? nm1 : rot_nx;
                    n_step = rot_nx;
                end
                MODE_CONNECTION: begin
                    n_col  = r_frame_color;
                    n_br   = {4'b0, br_d} * BREATH_GAIN;
                    n_step = (br_s == BREATH_LEN) ? '0 : STEP_W'(br_s + 5'd1);
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    always_comb begin
        emit     = (r_kind != K_ROTATE) || (r_idx == r_s) || (r_idx == r_nx) ||
                   (r_idx == r_pv);
        at_end   = (r_idx == r_end);
        out_free = !r_out_valid || !i_out_stall;
        if (r_kind == K_BLINK) begin
            pix_col = (r_idx[0] != r_phase) ? r_warning_color : DIM_RED;
        end else begin
            pix_col = r_col;
        end
        o_sts.silent   = (i_operation == OP_STEP) &&
                         (r_mode != MODE_CRITICAL) && (r_mode != MODE_STARTUP) &&
                         (r_mode != MODE_ROTATING) && (r_mode != MODE_CONNECTION);
        o_sts.out_free = out_free;
        o_sts.at_end   = at_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_color   <= '0;
            r_warning_color <= WARNING_RESET;
            r_pixel_count   <= COUNT_RESET;
            r_mode          <= MODE_NONE;
            r_step          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_COLOR:   r_frame_color   <= i_cfg_data;
                    CFG_WARNING_COLOR: r_warning_color <= i_cfg_data;
                    CFG_PIXEL_COUNT:   r_pixel_count   <= i_cfg_data[CNT_W-1:0];
                    default:           r_pixel_count   <= r_pixel_count;
                endcase
            end
            if (i_cmd.load_item) begin
                r_mode <= n_mode;
                r_step <= n_step;
            end
            if (i_cmd.advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind  <= n_kind;
            r_col   <= n_col;
            r_br    <= n_br;
            r_acc   <= n_acc;
            r_end   <= n_end;
            r_phase <= n_phase;
            r_s     <= n_s;
            r_nx    <= n_nx;
            r_pv    <= n_pv;
            r_idx   <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= PIX_W'(r_idx + PIX_W'(1));
        end
        if (i_cmd.advance && emit) begin
            r_pixel_index <= r_idx;
            r_pixel_color <= pix_col;
            r_brightness  <= r_br;
            r_accepted    <= r_acc;
            r_last_pixel  <= at_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_pixel_index;
    assign o_pixel_color = r_pixel_color;
    assign o_brightness  = r_brightness;
    assign o_accepted    = r_accepted;
    assign o_last_pixel  = r_last_pixel;

endmodule

// ----- rtl/lsas_ctrl.sv -----
module lsas_ctrl
    import lsas_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state;

    always_comb begin
        o_cmd.load_item = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.advance   = (r_state == ST_RUN) && i_sts.out_free;
        o_in_stall      = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid && !i_sts.silent) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (i_sts.out_free && i_sts.at_end) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/led_strip_animation_sequencer.sv -----
// LED strip pattern generator. A select transaction switches the animation mode and sends
// its opening frame, one pixel per clock unless the output stalls; a step transaction
// advances the active pattern and sends one pixel per lit LED in ascending order,
// last_pixel marking the final one. The pixel counter walks all n LED positions for
// full frames, up to n for the rotating window and lit+1 for startup, where n is
// pixel_count limited to 1..min(MAX_PIXELS, 64). A repeated select sends a single pixel
// with accepted low, and a step in the static or none mode sends no pixel. The counter
// waits whenever the output register is stalled; the next transaction is taken once the
// final pixel sits in the output register.
module led_strip_animation_sequencer
    import lsas_pkg::*;
#(
    parameter int MAX_PIXELS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_operation,
    input  logic [ANIM_W-1:0]    i_animation,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PIX_W-1:0]     o_pixel_index,
    output logic [COLOR_W-1:0]   o_pixel_color,
    output logic [BR_W-1:0]      o_brightness,
    output logic                 o_accepted,
    output logic                 o_last_pixel
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    lsas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (dp_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    lsas_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_operation),
        .i_animation   (i_animation),
        .i_out_stall   (i_out_stall),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .o_out_valid   (o_out_valid),
        .o_pixel_index (o_pixel_index),
        .o_pixel_color (o_pixel_color),
        .o_brightness  (o_brightness),
        .o_accepted    (o_accepted),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

// ----- rtl/lsas_checker.sv -----
`include "led_strip_animation_sequencer_assert.svh"

module lsas_checker
    import lsas_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [PIX_W-1:0]     o_pixel_index,
    input logic [COLOR_W-1:0]   o_pixel_color,
    input logic [BR_W-1:0]      o_brightness,
    input logic                 o_accepted,
    input logic                 o_last_pixel
);

    `LSAS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_pixel_index) && $stable(o_pixel_color) &&
        $stable(o_brightness) && $stable(o_accepted) && $stable(o_last_pixel),
        "stalled output transaction changed")

    `LSAS_ASSERT_IMP(a_reject_form, i_clk, i_rst_n, o_out_valid && !o_accepted,
        o_last_pixel && (o_pixel_index == '0) && (o_pixel_color == '0) &&
        (o_brightness == BR_FULL), "rejected select reply malformed")

    `LSAS_ASSERT_IMP(a_breath_range, i_clk, i_rst_n,
        o_out_valid && (o_brightness != BR_FULL),
        (o_brightness <= 8'd100) && o_accepted, "brightness outside breathing ramp")

    `LSAS_ASSERT_IMP(a_busy_mid_frame, i_clk, i_rst_n, o_out_valid && !o_last_pixel,
        o_in_stall, "input taken while a frame is still being sent")

endmodule

bind led_strip_animation_sequencer lsas_checker u_lsas_checker (.*);

// ----- sim/led_strip_frame_checker.sv -----
`timescale 1ns / 1ps

module led_strip_frame_checker
    import lsas_pkg::*;
#(
    parameter int MAX_PIXELS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_operation,
    input  logic [ANIM_W-1:0]    i_animation,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [PIX_W-1:0]     i_pixel_index,
    input  logic [COLOR_W-1:0]   i_pixel_color,
    input  logic [BR_W-1:0]      i_brightness,
    input  logic                 i_accepted,
    input  logic                 i_last_pixel,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_pixels_seen
);

    localparam logic [COLOR_W-1:0] DIM_RED_RGB = 24'h640000;
    localparam logic [BR_W-1:0]    FULL_BRIGHT = 8'd255;
    localparam int                 RAMP_END    = 20;
    localparam int                 RAMP_PEAK   = 10;
    localparam int                 RAMP_GAIN   = 10;

    typedef struct packed {
        logic [PIX_W-1:0]   index;
        logic [COLOR_W-1:0] color;
        logic [BR_W-1:0]    bright;
        logic               accepted;
        logic               last;
    } t_pixel;

    t_mode              cur_mode;
    logic [STEP_W-1:0]  cur_step;
    logic [COLOR_W-1:0] frame_rgb;
    logic [COLOR_W-1:0] warn_rgb;
    logic [CNT_W-1:0]   strip_count;
    t_pixel             pending_pixels[$];
    int                 fail_total  = 0;
    int                 pixels_seen = 0;

    function automatic int strip_length(input logic [CNT_W-1:0] count);
        int cap;
        int len;
        cap = (MAX_PIXELS > STRIP_MAX) ? STRIP_MAX : MAX_PIXELS;
        if (cap < 1) cap = 1;
        len = int'(count);
        if (len > cap) len = cap;
        if (len < 1) len = 1;
        return len;
    endfunction

    function automatic t_pixel make_pixel(input int idx, input logic [COLOR_W-1:0] rgb,
                                          input logic [BR_W-1:0] br, input logic acc);
        t_pixel px;
        px.index    = PIX_W'(idx);
        px.color    = rgb;
        px.bright   = br;
        px.accepted = acc;
        px.last     = 1'b0;
        return px;
    endfunction

    task automatic predict_pixels(input logic op, input logic [ANIM_W-1:0] anim);
        t_pixel             frame_buf[$];
        t_pixel             px;
        logic [COLOR_W-1:0] fill;
        int                 n;
        int                 lit;
        int                 s;
        int                 nx;
        int                 pv;
        int                 ramp;
        n = strip_length(strip_count);
        if (op == OP_SELECT) begin
            if (anim == cur_mode) begin
                frame_buf.push_back(make_pixel(0, '0, FULL_BRIGHT, 1'b0));
            end else begin
                fill = '0;
                case (anim)
                    MODE_CRITICAL: begin
                        cur_mode = MODE_CRITICAL;
                        cur_step = '0;
                        fill     = warn_rgb;
                    end
                    MODE_STARTUP: begin
                        cur_mode = MODE_STARTUP;
                        cur_step = '0;
                    end
                    MODE_ROTATING: begin
                        cur_mode = MODE_ROTATING;
                        cur_step = '0;
                    end
                    MODE_CONNECTION: begin
                        cur_mode = MODE_CONNECTION;
                        cur_step = '0;
                    end
                    MODE_STATIC: begin
                        cur_mode = MODE_STATIC;
                        fill     = frame_rgb;
                    end
                    default: begin
                        cur_mode = MODE_NONE;
                    end
                endcase
                for (int i = 0; i < n; i++)
                    frame_buf.push_back(make_pixel(i, fill, FULL_BRIGHT, 1'b1));
            end
        end else begin
            case (cur_mode)
                MODE_CRITICAL: begin
                    for (int i = 0; i < n; i++)
                        frame_buf.push_back(make_pixel(i,
                            (i[0] != cur_step[0]) ? warn_rgb : DIM_RED_RGB,
                            FULL_BRIGHT, 1'b1));
                    cur_step = cur_step[0] ? '0 : STEP_W'(1);
                end
                MODE_STARTUP: begin
                    lit = (int'(cur_step) < n) ? int'(cur_step) : n - 1;
                    for (int i = 0; i <= lit; i++)
                        frame_buf.push_back(make_pixel(i, frame_rgb, FULL_BRIGHT, 1'b1));
                    cur_step = STEP_W'(cur_step + STEP_W'(1));
                    if (lit + 1 >= n) cur_mode = MODE_STATIC;
                end
                MODE_ROTATING: begin
                    s  = (int'(cur_step) < n) ? int'(cur_step) : 0;
                    nx = (s == n - 1) ? 0 : s + 1;
                    pv = (s == 0) ? n - 1 : s - 1;
                    for (int i = 0; i < n; i++)
                        if (i == s || i == nx || i == pv)
                            frame_buf.push_back(make_pixel(i, frame_rgb, FULL_BRIGHT, 1'b1));
                    cur_step = STEP_W'(nx);
                end
                MODE_CONNECTION: begin
                    s    = (int'(cur_step) > RAMP_END) ? RAMP_END : int'(cur_step);
                    ramp = (s <= RAMP_PEAK) ? s * RAMP_GAIN : (RAMP_END - s) * RAMP_GAIN;
                    for (int i = 0; i < n; i++)
                        frame_buf.push_back(make_pixel(i, frame_rgb, BR_W'(ramp), 1'b1));
                    cur_step = (s == RAMP_END) ? '0 : STEP_W'(s + 1);
                end
                default: begin
                end
            endcase
        end
        foreach (frame_buf[j]) begin
            px      = frame_buf[j];
            px.last = (j == frame_buf.size() - 1);
            pending_pixels.push_back(px);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: pixel %0d %s: got 0x%0h, want 0x%0h",
                 $time, pixels_seen, what, got, want);
        fail_total++;
    endtask

    task automatic check_pixel();
        t_pixel want;
        pixels_seen++;
        if (pending_pixels.size() == 0) begin
            report_mismatch("arrived with no transaction pending", 32'(i_pixel_index), 0);
        end else begin
            want = pending_pixels.pop_front();
            if (i_pixel_index !== want.index)
                report_mismatch("pixel_index", 32'(i_pixel_index), 32'(want.index));
            if (i_pixel_color !== want.color)
                report_mismatch("pixel_color", 32'(i_pixel_color), 32'(want.color));
            if (i_brightness !== want.bright)
                report_mismatch("brightness", 32'(i_brightness), 32'(want.bright));
            if (i_accepted !== want.accepted)
                report_mismatch("accepted", 32'(i_accepted), 32'(want.accepted));
            if (i_last_pixel !== want.last)
                report_mismatch("last_pixel", 32'(i_last_pixel), 32'(want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode    = MODE_NONE;
            cur_step    = '0;
            frame_rgb   = '0;
            warn_rgb    = 24'hFF0000;
            strip_count = 7'd16;
            pending_pixels.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_pixel();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_COLOR:   frame_rgb   = i_cfg_data;
                    CFG_WARNING_COLOR: warn_rgb    = i_cfg_data;
                    CFG_PIXEL_COUNT:   strip_count = i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_pixels(i_operation, i_animation);
        end
        o_fail_count  = fail_total;
        o_pending     = pending_pixels.size();
        o_pixels_seen = pixels_seen;
    end

endmodule

// ----- sim/led_strip_animation_sequencer_test.sv -----
`timescale 1ns / 1ps

module led_strip_animation_sequencer_test;
    import lsas_pkg::*;

    localparam int STRIP_PIXELS   = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int RANDOM_ITEMS   = 150;
    localparam int PHASE_ITEMS    = 20;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COLOR_W-1:0]   cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 operation = 1'b0;
    logic [ANIM_W-1:0]    animation = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [PIX_W-1:0]     pixel_index;
    logic [COLOR_W-1:0]   pixel_color;
    logic [BR_W-1:0]      brightness;
    logic                 accepted;
    logic                 last_pixel;

    int fail_count;
    int pending;
    int pixels_seen;
    int send_gap_pct  = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    int items_sent    = 0;
    int items_covered = 0;
    int phase_count   = 0;
    int strip_n       = 16;

    always #4 clk = ~clk;

    led_strip_animation_sequencer #(
        .MAX_PIXELS(STRIP_PIXELS)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_operation  (operation),
        .i_animation  (animation),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_pixel_index(pixel_index),
        .o_pixel_color(pixel_color),
        .o_brightness (brightness),
        .o_accepted   (accepted),
        .o_last_pixel (last_pixel)
    );

    led_strip_frame_checker #(
        .MAX_PIXELS(STRIP_PIXELS)
    ) frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_operation  (operation),
        .i_animation  (animation),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_pixel_index(pixel_index),
        .i_pixel_color(pixel_color),
        .i_brightness (brightness),
        .i_accepted   (accepted),
        .i_last_pixel (last_pixel),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_pixels_seen(pixels_seen)
    );

    always @(negedge clk) begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [ANIM_W-1:0] anim);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid  = 1'b0;
            operation = 1'($urandom_range(0, 1));
            animation = ANIM_W'($urandom_range(0, 7));
            @(negedge clk);
        end
        in_valid  = 1'b1;
        operation = op;
        animation = anim;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        items_sent++;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(input logic [COLOR_W-1:0] frame_rgb,
                             input logic [COLOR_W-1:0] warn_rgb, input int count);
        logic [CNT_W-1:0] count_bits;
        count_bits = CNT_W'(count);
        drain();
        write_reg(CFG_FRAME_COLOR, frame_rgb);
        write_reg(CFG_WARNING_COLOR, warn_rgb);
        write_reg(CFG_PIXEL_COUNT, {(COLOR_W - CNT_W)'($urandom), count_bits});
        strip_n = (count_bits == 0) ? 1 : ((count_bits > STRIP_PIXELS) ? STRIP_PIXELS
                                                                        : int'(count_bits));
        phase_count++;
    endtask

    task automatic send_steps(input int reps);
        for (int k = 0; k < reps; k++)
            send_item(OP_STEP, ANIM_W'($urandom_range(0, 7)));
    endtask

    task automatic run_sequence();
        logic [ANIM_W-1:0] anim;
        int                run_len;
        int                live;
        if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 9) == 0) anim = ANIM_W'($urandom_range(6, 7));
            else anim = ANIM_W'($urandom_range(0, 5));
            send_item(OP_SELECT, anim);
            items_covered++;
            case (anim)
                MODE_CRITICAL, MODE_ROTATING: begin
                    run_len = $urandom_range(0, 7);
                    live    = run_len;
                end
                MODE_CONNECTION: begin
                    run_len = $urandom_range(0, 24);
                    live    = run_len;
                end
                MODE_STARTUP: begin
                    run_len = $urandom_range(0, (strip_n < 12) ? strip_n + 1 : 12);
                    live    = (run_len < strip_n) ? run_len : strip_n;
                end
                default: begin
                    run_len = $urandom_range(0, 1);
                    live    = 0;
                end
            endcase
            send_steps(run_len);
            items_covered += live;
        end else begin
            send_item(1'($urandom_range(0, 1)), ANIM_W'($urandom_range(0, 7)));
            items_covered++;
        end
    endtask

    initial begin
        int phase_start;
        int count_pick;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        configure(24'hFFFFFF, 24'h000000, 5);
        send_item(OP_STEP, MODE_NONE);
        send_item(OP_SELECT, MODE_NONE);
        send_item(OP_SELECT, MODE_CRITICAL);
        send_steps(2);
        send_item(OP_SELECT, MODE_STARTUP);
        send_steps(6);
        send_item(OP_SELECT, MODE_STATIC);
        send_item(OP_SELECT, MODE_CONNECTION);
        send_steps(2);
        send_item(OP_SELECT, 3'd6);
        send_item(OP_SELECT, 3'd7);

        // shrink the strip under a rotating window that sits past the new end
        configure(24'h000000, 24'hFFFFFF, 12);
        send_item(OP_SELECT, MODE_ROTATING);
        send_steps(5);
        configure(24'h5A5A5A, 24'hA5A5A5, 3);
        send_steps(2);

        while (items_covered < RANDOM_ITEMS) begin
            case (phase_count % 8)
                0: count_pick = 1;
                1: count_pick = 64;
                2: count_pick = $urandom_range(2, 8);
                3: count_pick = 0;
                4: count_pick = $urandom_range(1, 16);
                5: count_pick = 127;
                6: count_pick = 3;
                default: count_pick = $urandom_range(1, 12);
            endcase
            case (phase_count % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 70; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 70; end
                default: begin send_gap_pct = 38; stall_pct = 38; end
            endcase
            configure((phase_count % 3 == 0) ? 24'hFFFFFF :
                      (phase_count % 3 == 1) ? 24'h000000 : COLOR_W'($urandom),
                      (phase_count % 3 == 1) ? 24'hFFFFFF : COLOR_W'($urandom),
                      count_pick);
            phase_start = items_covered;
            while (items_covered - phase_start < PHASE_ITEMS && items_covered < RANDOM_ITEMS)
                run_sequence();
        end

        drain();
        $display("Sent %0d transactions across %0d register settings and all stall mixes;",
                 items_sent, phase_count);
        $display("%0d pixels compared, %0d mismatches.", pixels_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lsas_pkg.sv
rtl/lsas_datapath.sv
rtl/lsas_ctrl.sv
rtl/led_strip_animation_sequencer.sv
rtl/lsas_checker.sv
sim/led_strip_frame_checker.sv
sim/led_strip_animation_sequencer_test.sv
